/* sv/tbd_pkg.sv */
// ----------------------------------------------------------------------------
// tbd_pkg: shared types and constants for the three-button debouncer
// Widths, the debounce reset value, result codes and the per-button level flags.
// ----------------------------------------------------------------------------
package tbd_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int DEB_W          = 16;
  localparam int NUM_BUTTONS    = 3;
  localparam int BTN_W          = 2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

  // Result codes
  localparam logic [BTN_W-1:0] BTN_NONE      = 2'd0;
  localparam logic [BTN_W-1:0] BTN_POWER     = 2'd1;
  localparam logic [BTN_W-1:0] BTN_EMERGENCY = 2'd2;
  localparam logic [BTN_W-1:0] BTN_INFO      = 2'd3;

  // Per-button levels, 1 means pressed
  typedef struct packed {
    logic raw_down;
    logic stable_down;
  } button_state_t;

endpackage

/* sv/three_button_debounce_priority.sv */
// ----------------------------------------------------------------------------
// three_button_debounce_priority: time-based debouncer for three buttons
// One poll request carries a time stamp and three active-low pin levels;
// one response reports the first newly pressed button in order A, B, C (none on a resync).
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  in       | in_valid, in_stall | func, now_ms, level_a, level_b, level_c
//  out      | out_valid,out_stall| pressed_button
//  config   | cfg_we             | cfg_wdata (debounce_time)
//
// One request per cycle, sustained while the response side does not stall. A
// request passes from the input register into the result register, which
// presents the response until it is taken.
// The button state (raw, stable, change time) is updated
// as a request moves from the input register into the result register.
// Reset clears both registers, the button state and restores the debounce
// time to 50. A stalled response holds the input register, which then
// raises in_stall; with the result register empty no stall reaches in.
// ----------------------------------------------------------------------------
module three_button_debounce_priority #(
  parameter int TIME_WIDTH = tbd_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [tbd_pkg::DEB_W-1:0]   cfg_wdata,
  // poll requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        func,
  input  logic [tbd_pkg::NOW_W-1:0]   now_ms,
  input  logic                        level_a,
  input  logic                        level_b,
  input  logic                        level_c,
  // responses
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbd_pkg::BTN_W-1:0]   pressed_button
);
  import tbd_pkg::*;

  // Configuration
  logic [DEB_W-1:0] debounce_time;

  // Input register
  logic                   s1_valid;
  logic                   s1_func;
  logic [NOW_W-1:0]       s1_now;
  logic [NUM_BUTTONS-1:0] s1_down;
  logic [TIME_WIDTH-1:0]  now_time;
  logic                   s1_advance;
  logic                   in_accept;

  // Button state
  button_state_t         state        [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0] changed_time [NUM_BUTTONS];
  button_state_t         chk_state    [NUM_BUTTONS];
  logic [TIME_WIDTH-1:0] chk_changed  [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] chk_press;
  logic [NUM_BUTTONS-1:0] chk_enable;

  logic [BTN_W-1:0] result;

  // Drop the request into the result register whenever that register is
  // empty or its content is being taken this cycle.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // Cut or extend the time stamp to the counter width
  generate
    if (TIME_WIDTH >= NOW_W) begin : g_now_ext
      assign now_time = TIME_WIDTH'(s1_now);
    end else begin : g_now_cut
      assign now_time = s1_now[TIME_WIDTH-1:0];
    end
  endgenerate

  // One check per button; each runs on its own stored state
  genvar k;
  generate
    for (k = 0; k < NUM_BUTTONS; k++) begin : g_btn
      tbd_button #(
        .TIME_WIDTH (TIME_WIDTH)
      ) u_button (
        .down              (s1_down[k]),
        .now_time          (now_time),
        .debounce_time     (debounce_time),
        .state             (state[k]),
        .changed_time      (changed_time[k]),
        .state_next        (chk_state[k]),
        .changed_time_next (chk_changed[k]),
        .press             (chk_press[k])
      );
    end
  endgenerate

  // A button is sampled only if no earlier button reported a press
  always_comb begin
    chk_enable[0] = 1'b1;
    for (int i = 1; i < NUM_BUTTONS; i++) begin
      chk_enable[i] = chk_enable[i-1] && !chk_press[i-1];
    end
  end

  // Pick the first press in order A, B, C; a resync reports none
  always_comb begin
    priority if (s1_func) begin
      result = BTN_NONE;
    end else if (chk_press[0]) begin
      result = BTN_POWER;
    end else if (chk_press[1]) begin
      result = BTN_EMERGENCY;
    end else if (chk_press[2]) begin
      result = BTN_INFO;
    end else begin
      result = BTN_NONE;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      debounce_time <= cfg_wdata;
    end
  end

  // Input register: hold while stalled, load on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func <= func;
      s1_now  <= now_ms;
      s1_down <= ~{level_c, level_b, level_a};
    end
  end

  // Button state: resync takes the current levels, a poll takes the
  // checked values of every button still in play
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        state[i]        <= '0;
        changed_time[i] <= '0;
      end
    end else if (s1_advance) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (s1_func) begin
          state[i].raw_down    <= s1_down[i];
          state[i].stable_down <= s1_down[i];
          changed_time[i]      <= now_time;
        end else if (chk_enable[i]) begin
          state[i]        <= chk_state[i];
          changed_time[i] <= chk_changed[i];
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      pressed_button <= result;
    end
  end

endmodule

/* sv/tbd_button.sv */
// ----------------------------------------------------------------------------
// tbd_button: debounce check for one button
// Tracks a raw level change, checks the hold time against the debounce
// time and reports a stable change to pressed.
// ----------------------------------------------------------------------------
module tbd_button #(
  parameter int TIME_WIDTH = tbd_pkg::TIME_WIDTH_DEF
) (
  input  logic                        down,
  input  logic [TIME_WIDTH-1:0]       now_time,
  input  logic [tbd_pkg::DEB_W-1:0]   debounce_time,
  input  tbd_pkg::button_state_t      state,
  input  logic [TIME_WIDTH-1:0]       changed_time,
  output tbd_pkg::button_state_t      state_next,
  output logic [TIME_WIDTH-1:0]       changed_time_next,
  output logic                        press
);
  import tbd_pkg::*;

  localparam int CMP_W = (TIME_WIDTH > DEB_W) ? TIME_WIDTH : DEB_W;

  logic [TIME_WIDTH-1:0] elapsed;
  logic                  held;

  // Modulo subtraction handles a wrapping time stamp
  assign elapsed = now_time - changed_time;
  assign held    = CMP_W'(elapsed) >= CMP_W'(debounce_time);

  always_comb begin
    state_next        = state;
    changed_time_next = changed_time;
    press             = 1'b0;
    priority if (down != state.raw_down) begin
      state_next.raw_down = down;
      changed_time_next   = now_time;
    end else if (down != state.stable_down && held) begin
      state_next.stable_down = down;
      press                  = down;
    end else begin
      // hold: already stable, or not held long enough yet
      press = 1'b0;
    end
  end

endmodule

/* sv/tbd_check.sv */
// ----------------------------------------------------------------------------
// tbd_check: port-level checks for the three-button debouncer
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module tbd_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tbd_pkg::BTN_W-1:0] pressed_button
);
  import tbd_pkg::*;

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("response or stall present after reset");

  // With the result register empty the input side never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall raised with no response pending");

  // A stalled response stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed_button))
    else $error("stalled response dropped or changed");

  // An accepted request always turns into a response unless the output side
  // stalls
  a_response_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall |=> out_valid)
    else $error("accepted request produced no response");

endmodule

bind three_button_debounce_priority tbd_check u_tbd_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .pressed_button (pressed_button)
);
